@@ src/qpt_pkg.sv @@
// qpt_pkg: widths, register indexes and constants of the quaternion point transform.
// No dependencies; used by quaternion_point_transform_unit.
package qpt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int QUAT_WIDTH  = 32;
  localparam int QFRAC       = QUAT_WIDTH - 2;
  localparam int CFG_W       = (QUAT_WIDTH > COORD_WIDTH) ? QUAT_WIDTH : COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;

  // product of quaternion and coordinate, and the cross difference
  localparam int P1_W = QUAT_WIDTH + COORD_WIDTH;
  localparam int D_W  = P1_W + 1;
  // u component after rounding by 2^(F-1)
  localparam int U_W  = D_W - (QFRAC - 1);
  // second product level and the three-term sum
  localparam int P2_W = QUAT_WIDTH + U_W;
  localparam int T_W  = P2_W + 2;
  // rotated term after rounding by 2^F, and the final sum
  localparam int R_W  = T_W - QFRAC;
  localparam int S_W  = R_W + 1;
  localparam int PS_W = COORD_WIDTH + 1;

  localparam int PIPE_DEPTH = 5;

  localparam logic signed [D_W-1:0] U_HALF = D_W'(1) << (QFRAC - 2);
  localparam logic signed [T_W-1:0] T_HALF = T_W'(1) << (QFRAC - 1);

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << QFRAC;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [QUAT_WIDTH-1:0]  quat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAT_W  = 3'd0,
    CFG_QUAT_X  = 3'd1,
    CFG_QUAT_Y  = 3'd2,
    CFG_QUAT_Z  = 3'd3,
    CFG_SHIFT_X = 3'd4,
    CFG_SHIFT_Y = 3'd5,
    CFG_SHIFT_Z = 3'd6
  } cfg_reg_t;

endpackage

@@ src/quaternion_point_transform_unit.sv @@
// quaternion_point_transform_unit: rotates a point by a unit quaternion, then translates it.
// Depends on qpt_pkg for widths, constants and register indexes.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  input    | in_point_x/y/z                          | word taken when start && !busy
//  result   | out_x/y/z, out_overflow                 | out_valid strobe, one cycle
//  config   | cfg_we, cfg_index, cfg_wdata            | write on cfg_we, no wait
//
// Cycles: one point per clock. The pipeline is built from the
// two multiply levels (q x p, then w*u and q x u), each followed by its own add/round stage,
// and a last stage for rounding, translation and saturation.
// busy is never raised. The receiver cannot stall, so the pipeline never stops.
// Reset (synchronous, rst_n low) clears the valid bits and loads the identity transform.
// Configuration is only to be written while no word is in flight.
module quaternion_point_transform_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qpt_pkg::COORD_WIDTH-1:0] in_point_x,
  input  logic signed [qpt_pkg::COORD_WIDTH-1:0] in_point_y,
  input  logic signed [qpt_pkg::COORD_WIDTH-1:0] in_point_z,
  output logic                                out_valid,
  output logic signed [qpt_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [qpt_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [qpt_pkg::COORD_WIDTH-1:0] out_z,
  output logic                                out_overflow,
  input  logic                                cfg_we,
  input  logic [qpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qpt_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int C = qpt_pkg::COORD_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers: quat_r[0] is w, quat_r[1..3] the vector part.
  // ---------------------------------------------------------------------------
  qpt_pkg::quat_t  quat_r  [4];
  qpt_pkg::coord_t shift_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[0]  <= qpt_pkg::QUAT_ONE;
      quat_r[1]  <= '0;
      quat_r[2]  <= '0;
      quat_r[3]  <= '0;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qpt_pkg::CFG_QUAT_W:  quat_r[0]  <= cfg_wdata[qpt_pkg::QUAT_WIDTH-1:0];
        qpt_pkg::CFG_QUAT_X:  quat_r[1]  <= cfg_wdata[qpt_pkg::QUAT_WIDTH-1:0];
        qpt_pkg::CFG_QUAT_Y:  quat_r[2]  <= cfg_wdata[qpt_pkg::QUAT_WIDTH-1:0];
        qpt_pkg::CFG_QUAT_Z:  quat_r[3]  <= cfg_wdata[qpt_pkg::QUAT_WIDTH-1:0];
        qpt_pkg::CFG_SHIFT_X: shift_r[0] <= cfg_wdata[C-1:0];
        qpt_pkg::CFG_SHIFT_Y: shift_r[1] <= cfg_wdata[C-1:0];
        qpt_pkg::CFG_SHIFT_Z: shift_r[2] <= cfg_wdata[C-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits, one per stage. Nothing ever holds the pipe.
  // ---------------------------------------------------------------------------
  logic                           accept;
  logic [qpt_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [qpt_pkg::PIPE_DEPTH-1:0] vld_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    vld_nxt = {vld_r[qpt_pkg::PIPE_DEPTH-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload pipeline
  //   S1: q_j*p_k and q_k*p_j per axis, p + shift
  //   S2: u_i = round((q_j*p_k - q_k*p_j) / 2^(F-1))
  //   S3: w*u_i, q_j*u_k, q_k*u_j
  //   S4: exact three-term sum
  //   S5: round by 2^F, add p + shift, saturate
  // ---------------------------------------------------------------------------
  qpt_pkg::coord_t pt [3];
  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  logic signed [qpt_pkg::P1_W-1:0] s1_pa_r  [3];
  logic signed [qpt_pkg::P1_W-1:0] s1_pb_r  [3];
  logic signed [qpt_pkg::PS_W-1:0] s1_ps_r  [3];
  logic signed [qpt_pkg::U_W-1:0]  s2_u_r   [3];
  logic signed [qpt_pkg::PS_W-1:0] s2_ps_r  [3];
  logic signed [qpt_pkg::P2_W-1:0] s3_wu_r  [3];
  logic signed [qpt_pkg::P2_W-1:0] s3_qa_r  [3];
  logic signed [qpt_pkg::P2_W-1:0] s3_qb_r  [3];
  logic signed [qpt_pkg::PS_W-1:0] s3_ps_r  [3];
  logic signed [qpt_pkg::T_W-1:0]  s4_t_r   [3];
  logic signed [qpt_pkg::PS_W-1:0] s4_ps_r  [3];
  qpt_pkg::coord_t                 out_r    [3];
  logic [2:0]                      ovf_r;

  logic signed [qpt_pkg::P1_W-1:0] s1_pa_nxt [3];
  logic signed [qpt_pkg::P1_W-1:0] s1_pb_nxt [3];
  logic signed [qpt_pkg::PS_W-1:0] s1_ps_nxt [3];
  logic signed [qpt_pkg::D_W-1:0]  s2_d      [3];
  logic signed [qpt_pkg::U_W-1:0]  s2_u_nxt  [3];
  logic signed [qpt_pkg::P2_W-1:0] s3_wu_nxt [3];
  logic signed [qpt_pkg::P2_W-1:0] s3_qa_nxt [3];
  logic signed [qpt_pkg::P2_W-1:0] s3_qb_nxt [3];
  logic signed [qpt_pkg::T_W-1:0]  s4_t_nxt  [3];
  logic signed [qpt_pkg::T_W-1:0]  s5_tr     [3];
  logic signed [qpt_pkg::R_W-1:0]  s5_rot    [3];
  logic signed [qpt_pkg::S_W-1:0]  s5_sum    [3];
  qpt_pkg::coord_t                 out_nxt   [3];
  logic [2:0]                      ovf_nxt;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_comb begin
      s1_pa_nxt[i] = quat_r[J+1] * pt[K];
      s1_pb_nxt[i] = quat_r[K+1] * pt[J];
      s1_ps_nxt[i] = qpt_pkg::PS_W'(pt[i]) + qpt_pkg::PS_W'(shift_r[i]);

      s2_d[i]      = qpt_pkg::D_W'(s1_pa_r[i]) - qpt_pkg::D_W'(s1_pb_r[i]) + qpt_pkg::U_HALF;
      s2_u_nxt[i]  = s2_d[i][qpt_pkg::D_W-1:qpt_pkg::QFRAC-1];

      s3_wu_nxt[i] = quat_r[0]   * s2_u_r[i];
      s3_qa_nxt[i] = quat_r[J+1] * s2_u_r[K];
      s3_qb_nxt[i] = quat_r[K+1] * s2_u_r[J];

      s4_t_nxt[i]  = qpt_pkg::T_W'(s3_wu_r[i]) + qpt_pkg::T_W'(s3_qa_r[i])
                   - qpt_pkg::T_W'(s3_qb_r[i]);

      s5_tr[i]     = s4_t_r[i] + qpt_pkg::T_HALF;
      s5_rot[i]    = s5_tr[i][qpt_pkg::T_W-1:qpt_pkg::QFRAC];
      s5_sum[i]    = qpt_pkg::S_W'(s5_rot[i]) + qpt_pkg::S_W'(s4_ps_r[i]);

      // out of range when the bits above the sign are not all copies of it
      ovf_nxt[i]   = !((&s5_sum[i][qpt_pkg::S_W-1:C-1]) || !(|s5_sum[i][qpt_pkg::S_W-1:C-1]));
      if (!ovf_nxt[i]) begin
        out_nxt[i] = s5_sum[i][C-1:0];
      end else if (s5_sum[i][qpt_pkg::S_W-1]) begin
        out_nxt[i] = qpt_pkg::COORD_MIN;
      end else begin
        out_nxt[i] = qpt_pkg::COORD_MAX;
      end
    end

    always_ff @(posedge clk) begin
      s1_pa_r[i] <= s1_pa_nxt[i];
      s1_pb_r[i] <= s1_pb_nxt[i];
      s1_ps_r[i] <= s1_ps_nxt[i];
      s2_u_r[i]  <= s2_u_nxt[i];
      s2_ps_r[i] <= s1_ps_r[i];
      s3_wu_r[i] <= s3_wu_nxt[i];
      s3_qa_r[i] <= s3_qa_nxt[i];
      s3_qb_r[i] <= s3_qb_nxt[i];
      s3_ps_r[i] <= s2_ps_r[i];
      s4_t_r[i]  <= s4_t_nxt[i];
      s4_ps_r[i] <= s3_ps_r[i];
      out_r[i]   <= out_nxt[i];
      ovf_r[i]   <= ovf_nxt[i];
    end
  end

  assign out_valid    = vld_r[qpt_pkg::PIPE_DEPTH-1];
  assign out_x        = out_r[0];
  assign out_y        = out_r[1];
  assign out_z        = out_r[2];
  assign out_overflow = |ovf_r;

`ifndef SYNTH
  // a result strobe appears for each accepted word once it has passed through the valid bits
  a_latency: assert property (@(posedge clk)
    (rst_n && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
     && $past(rst_n, 5))
    |-> (out_valid == $past(accept, qpt_pkg::PIPE_DEPTH)))
    else $error("result strobe does not match accepted words");

  // a flagged result carries a clamped coordinate
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow)
    |-> (out_x == qpt_pkg::COORD_MAX || out_x == qpt_pkg::COORD_MIN ||
         out_y == qpt_pkg::COORD_MAX || out_y == qpt_pkg::COORD_MIN ||
         out_z == qpt_pkg::COORD_MAX || out_z == qpt_pkg::COORD_MIN))
    else $error("overflow flagged without a clamped coordinate");

  // with a zero vector part the cross product term vanishes
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && quat_r[1] == '0 && quat_r[2] == '0 && quat_r[3] == '0)
    |-> (s2_u_r[0] == '0 && s2_u_r[1] == '0 && s2_u_r[2] == '0))
    else $error("nonzero u with zero quaternion vector");
`endif

endmodule

@@ test/quaternion_point_transform_unit_tb.sv @@
// quaternion_point_transform_unit_tb: self-checking bench for the point transform.
// Predicts every word in exact wide integer arithmetic and compares it field by field.
// Depends on qpt_pkg and quaternion_point_transform_unit.
module quaternion_point_transform_unit_tb;
  import qpt_pkg::*;

  // Wide enough for every intermediate product and sum, so nothing wraps.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   ovf;
  } xform_t;

  // Index 7 exists on the port but maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;
  localparam int MAX_REPORTS = 10;

  localparam coord_t COORD_ONE  = coord_t'(1) <<< 16;   // 1.0 in Q16.16
  localparam quat_t  QUAT_TOP   = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
  localparam quat_t  QUAT_BOTTOM = {1'b1, {(QUAT_WIDTH-1){1'b0}}};
  localparam quat_t  QUAT_COS45 = quat_t'(759250125);  // sqrt(2)/2 in Q1.30

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  coord_t in_point_z = '0;
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   out_overflow;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the transform registers, loaded with the reset values.
  quat_t  rot_w = QUAT_ONE;
  quat_t  rot_x = '0;
  quat_t  rot_y = '0;
  quat_t  rot_z = '0;
  coord_t off_x = '0;
  coord_t off_y = '0;
  coord_t off_z = '0;

  xform_t pending_points[$];   // predicted words, oldest first

  bit gaps_on = 1'b0;          // sender inserts random idle cycles
  int sent = 0;
  int checked = 0;
  int saturated = 0;
  int mismatches = 0;
  int settings = 0;

  quaternion_point_transform_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .out_valid    (out_valid),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_overflow (out_overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round(v / 2^s) with halves going up: add half an LSB, then floor.
  function automatic wide_t round_shift(wide_t v, int s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  // p' = p + w*u + q x u with u = 2(q x p), then the offset, then clamp.
  // u is rounded to coordinate units first, the rotated term once more at the end.
  function automatic xform_t transform_point(coord_t px, coord_t py, coord_t pz);
    wide_t  q[3];
    wide_t  p[3];
    wide_t  sh[3];
    wide_t  u[3];
    wide_t  w;
    wide_t  t;
    wide_t  r;
    coord_t o[3];
    xform_t res;
    int     j;
    int     k;
    w = wide_t'(rot_w);
    q[0] = wide_t'(rot_x);  q[1] = wide_t'(rot_y);  q[2] = wide_t'(rot_z);
    p[0] = wide_t'(px);     p[1] = wide_t'(py);     p[2] = wide_t'(pz);
    sh[0] = wide_t'(off_x); sh[1] = wide_t'(off_y); sh[2] = wide_t'(off_z);
    res.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      u[i] = round_shift(q[j] * p[k] - q[k] * p[j], QFRAC - 1);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      t = w * u[i] + q[j] * u[k] - q[k] * u[j];
      r = p[i] + sh[i] + round_shift(t, QFRAC);
      if (r > wide_t'(COORD_MAX)) begin
        r = wide_t'(COORD_MAX);
        res.ovf = 1'b1;
      end else if (r < wide_t'(COORD_MIN)) begin
        r = wide_t'(COORD_MIN);
        res.ovf = 1'b1;
      end
      o[i] = coord_t'(r);
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  // Coordinates spread over small, medium, full-range and edge values.
  function automatic coord_t rand_coord();
    int v;
    case ($urandom_range(0, 5))
      0, 1: begin
        v = $urandom_range(0, 1 << 21);
        return coord_t'(v - (1 << 20));
      end
      2: begin
        v = $urandom_range(0, 1 << 27);
        return coord_t'(v - (1 << 26));
      end
      3, 4: return coord_t'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return coord_t'(-1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Quaternion component within [-1.0, 1.0].
  function automatic quat_t rand_quat_ranged();
    logic [31:0] v;
    v = $urandom_range(0, 32'h8000_0000);
    return quat_t'(v - 32'h4000_0000);
  endfunction

  // Checker: every strobe must match the oldest prediction.
  always @(posedge clk) begin : result_check
    xform_t want;
    logic   bad;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected word: x=%0d y=%0d z=%0d ovf=%0b",
                   out_x, out_y, out_z, out_overflow);
      end else begin
        want = pending_points.pop_front();
        bad = (out_x !== want.x) || (out_y !== want.y) || (out_z !== want.z) ||
              (out_overflow !== want.ovf);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch on word %0d: expected x=%0d y=%0d z=%0d ovf=%0b, got x=%0d y=%0d z=%0d ovf=%0b",
                     checked, want.x, want.y, want.z, want.ovf,
                     out_x, out_y, out_z, out_overflow);
        end
        if (want.ovf)
          saturated++;
        checked++;
      end
    end
  end

  // Drop start and let the pipeline empty out; config may only change then.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_points.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_QUAT_W:  rot_w = quat_t'(val);
      CFG_QUAT_X:  rot_x = quat_t'(val);
      CFG_QUAT_Y:  rot_y = quat_t'(val);
      CFG_QUAT_Z:  rot_z = quat_t'(val);
      CFG_SHIFT_X: off_x = coord_t'(val);
      CFG_SHIFT_Y: off_y = coord_t'(val);
      CFG_SHIFT_Z: off_z = coord_t'(val);
      default: ;  // unmapped index: the block ignores it
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_rotation(quat_t w, quat_t x, quat_t y, quat_t z);
    settle();
    write_reg(CFG_QUAT_W, CFG_W'(w));
    write_reg(CFG_QUAT_X, CFG_W'(x));
    write_reg(CFG_QUAT_Y, CFG_W'(y));
    write_reg(CFG_QUAT_Z, CFG_W'(z));
    settings++;
  endtask

  task automatic set_shift(coord_t x, coord_t y, coord_t z);
    settle();
    write_reg(CFG_SHIFT_X, CFG_W'(x));
    write_reg(CFG_SHIFT_Y, CFG_W'(y));
    write_reg(CFG_SHIFT_Z, CFG_W'(z));
    settings++;
  endtask

  // Send one point. start stays high after acceptance so back-to-back words
  // need no extra step; a gap drops it first.
  task automatic send_point(coord_t px, coord_t py, coord_t pz);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (busy);
    pending_points.push_back(transform_point(px, py, pz));
    sent++;
  endtask

  // Reset values give the identity; then offsets at the coordinate limits.
  task automatic test_identity_and_offsets();
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MIN, coord_t'(-1));
    send_point(coord_t'(1), coord_t'(-1), COORD_ONE);
    set_shift(COORD_MAX, COORD_MIN, '0);
    send_point(COORD_MAX, COORD_MIN, coord_t'(1));        // clamps high and low
    send_point(coord_t'(-1), coord_t'(1), COORD_MIN);     // just inside
    set_shift(COORD_MIN, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, coord_t'(-1));
    set_shift('0, '0, '0);
  endtask

  task automatic test_axis_rotations();
    // quarter turn about z: x axis maps onto y
    set_rotation(QUAT_COS45, '0, '0, QUAT_COS45);
    send_point(COORD_ONE, '0, '0);
    send_point('0, 3 * COORD_ONE, -2 * COORD_ONE);
    // half turn about x, exact; negating the minimum clips
    set_rotation('0, QUAT_ONE, '0, '0);
    send_point(COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    // half turn about y
    set_rotation('0, '0, QUAT_ONE, '0);
    send_point(COORD_ONE, -5 * COORD_ONE, COORD_MAX);
    // w = -1.0 is still the identity
    set_rotation(-QUAT_ONE, '0, '0, '0);
    send_point(coord_t'(32'h1234_5678), coord_t'(-7), COORD_MAX);
  endtask

  // No normalization: non-unit and out-of-range quaternions are used as they are.
  task automatic test_odd_quaternions();
    set_rotation(QUAT_ONE, QUAT_ONE, QUAT_ONE, QUAT_ONE);
    send_point(COORD_ONE, -2 * COORD_ONE, COORD_ONE >>> 1);
    send_point(coord_t'(3), coord_t'(-3), coord_t'(1));   // rounding at the LSB
    set_rotation(QUAT_TOP, QUAT_BOTTOM, QUAT_TOP, QUAT_BOTTOM);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(coord_t'(5), coord_t'(-9), coord_t'(2));
    set_rotation(QUAT_BOTTOM, QUAT_BOTTOM, QUAT_BOTTOM, QUAT_BOTTOM);
    send_point(COORD_MIN, COORD_MAX, coord_t'(100));
    // write to the unmapped index must not disturb anything
    settle();
    write_reg(CFG_UNMAPPED, '1);
    send_point(COORD_ONE, COORD_ONE, -COORD_ONE);
  endtask

  task automatic test_random_traffic();
    real a, b, c, d, n;
    for (int phase = 0; phase < 12; phase++) begin
      gaps_on = (phase % 3) != 0;   // every third phase runs gapless
      case (phase % 4)
        0, 3: begin
          // unit quaternion from a random direction
          a = $itor($urandom_range(0, 2000)) - 1000.0;
          b = $itor($urandom_range(0, 2000)) - 1000.0;
          c = $itor($urandom_range(0, 2000)) - 1000.0;
          d = $itor($urandom_range(0, 2000)) - 1000.0;
          n = $sqrt(a * a + b * b + c * c + d * d);
          if (n == 0.0)
            set_rotation(QUAT_ONE, '0, '0, '0);
          else
            set_rotation(quat_t'($rtoi(a / n * 2.0 ** QFRAC)),
                         quat_t'($rtoi(b / n * 2.0 ** QFRAC)),
                         quat_t'($rtoi(c / n * 2.0 ** QFRAC)),
                         quat_t'($rtoi(d / n * 2.0 ** QFRAC)));
        end
        1: set_rotation(rand_quat_ranged(), rand_quat_ranged(),
                        rand_quat_ranged(), rand_quat_ranged());
        default: set_rotation(quat_t'($urandom()), quat_t'($urandom()),
                              quat_t'($urandom()), quat_t'($urandom()));
      endcase
      case ($urandom_range(0, 3))
        0: set_shift('0, '0, '0);
        1: set_shift(coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24)),
                     coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24)),
                     coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24)));
        2: set_shift(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
        default: set_shift($urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                           $urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                           coord_t'($urandom()));
      endcase
      if (phase == 5) begin
        settle();
        write_reg(CFG_UNMAPPED, CFG_W'($urandom()));
      end
      repeat (52) send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_identity_and_offsets();
    test_axis_rotations();
    test_odd_quaternions();
    test_random_traffic();

    // drain, bounded, then wait on to catch stray strobes
    @(negedge clk);
    start <= 1'b0;
    for (int n = 0; n < 1000 && pending_points.size() != 0; n++)
      @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (pending_points.size() != 0) begin
      mismatches++;
      $display("%0d predicted words never arrived", pending_points.size());
    end

    $display("Sent %0d points, checked %0d words over %0d register settings, %0d saturated.",
             sent, checked, settings, saturated);
    $display("Covered identity, axis turns, non-unit and out-of-range quaternions, offset limits.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: ends the run if the block hangs.
  initial begin
    #500000;
    $display("Timeout waiting on the block");
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
src/qpt_pkg.sv
src/quaternion_point_transform_unit.sv
test/quaternion_point_transform_unit_tb.sv
